>>> hdl/fwtt_pkg.sv
// shared types and constants for the four-way transposition table
// no dependencies
package fwtt_pkg;

  localparam int Entries   = 4096;
  localparam int PlyUnit   = 4;
  localparam int IdxW      = $clog2(Entries);
  localparam int BktW      = IdxW - 2;
  localparam int PayW      = 54;
  localparam int KeyW      = 64;
  localparam logic [14:0] MateThrRst = 15'd30000;

  localparam logic [1:0] MODE_PROBE  = 2'd0;
  localparam logic [1:0] MODE_REFINE = 2'd1;
  localparam logic [1:0] MODE_STORE  = 2'd2;
  localparam logic [1:0] MODE_AGE    = 2'd3;

  typedef struct packed {
    logic [1:0]         mode;
    logic [63:0]        key;
    logic [15:0]        move_in;
    logic signed [15:0] score_in;
    logic signed [15:0] alpha;
    logic signed [15:0] beta;
    logic [11:0]        depth;
    logic [7:0]         ply;
    logic [1:0]         bound_flags;
  } in_item_t;

  typedef struct packed {
    logic               hit;
    logic               cutoff;
    logic [15:0]        move_out;
    logic signed [15:0] score_out;
  } out_item_t;

  typedef struct packed {
    logic [7:0]         date;
    logic [15:0]        move;
    logic signed [15:0] score;
    logic [1:0]         flags;
    logic [11:0]        depth;
  } payload_t;

  // saturate a 18-bit signed value to 16 bits
  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) r = 16'sh7fff;
    else if (v < -18'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage

>>> hdl/fwtt_queue.sv
// two-entry queue between front and back parts
// depends on fwtt_pkg
module fwtt_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  fwtt_pkg::in_item_t push_data,
  output logic               full,
  input  logic               pop,
  output logic               empty,
  output fwtt_pkg::in_item_t pop_data
);
  import fwtt_pkg::*;

  in_item_t   mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

>>> hdl/fwtt_back.sv
// back part: clearing pass, bucket read, way compare, write back, result register
// depends on fwtt_pkg
module fwtt_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [14:0]        mate_thr,
  input  logic               q_empty,
  input  fwtt_pkg::in_item_t q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output fwtt_pkg::out_item_t out_data
);
  import fwtt_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_READ  = 4'b0100,
    ST_EXEC  = 4'b1000
  } state_t;

  logic [KeyW-1:0] key_mem [4][Entries/4];
  logic [PayW-1:0] pay_mem [4][Entries/4];
  logic [KeyW-1:0] rkey [4];
  payload_t        rpay [4];

  state_t     state_r, state_nxt;
  logic [BktW:0] clr_r;
  logic [7:0] age_r;
  in_item_t   it_r;
  logic       ov_r;
  out_item_t  od_r;

  logic [BktW-1:0] bkt;
  assign bkt = it_r.key[IdxW-1:2];

  logic            we;
  logic [3:0]      we_way;
  logic [BktW-1:0] waddr;
  logic [KeyW-1:0] wkey;
  payload_t        wpay;

  // bucket memories, one bank per way; read address follows the held beat
  for (genvar w = 0; w < 4; w++) begin : g_way
    always_ff @(posedge clk) begin
      if (we && we_way[w]) begin
        key_mem[w][waddr] <= wkey;
        pay_mem[w][waddr] <= wpay;
      end
      rkey[w] <= key_mem[w][bkt];
      rpay[w] <= pay_mem[w][bkt];
    end
  end

  // compare and choose
  logic [3:0] match;
  logic       any_hit;
  logic [1:0] hw;
  logic [1:0] pick;
  logic signed [17:0] rep [4];
  logic signed [17:0] best;
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      match[i] = (rkey[i] == it_r.key);
      rep[i] = $signed({2'b00, 8'(age_r - rpay[i].date), 8'hff})
             - $signed(18'(rpay[i].depth / PlyUnit));
    end
    any_hit = |match;
    hw = 2'd0;
    priority if (match[0]) hw = 2'd0;
    else if (match[1]) hw = 2'd1;
    else if (match[2]) hw = 2'd2;
    else if (match[3]) hw = 2'd3;
    else hw = 2'd0;
    pick = 2'd0;
    best = rep[0];
    for (int i = 1; i < 4; i++) begin
      if (rep[i] > best) begin
        best = rep[i];
        pick = 2'(i);
      end
    end
  end

  payload_t hp;
  assign hp = rpay[hw];

  logic signed [17:0] thr_s, ply_s, es_adj, ss_adj;
  logic signed [15:0] pscore, sscore, rscore;
  logic deep, cut;
  always_comb begin
    thr_s = $signed({3'b000, mate_thr});
    ply_s = $signed({10'd0, it_r.ply});
    es_adj = 18'(hp.score);
    if (18'(hp.score) < -thr_s) es_adj = 18'(hp.score) + ply_s;
    else if (18'(hp.score) > thr_s) es_adj = 18'(hp.score) - ply_s;
    pscore = sat16(es_adj);
    ss_adj = 18'(it_r.score_in);
    if (18'(it_r.score_in) < -thr_s) ss_adj = 18'(it_r.score_in) - ply_s;
    else if (18'(it_r.score_in) > thr_s) ss_adj = 18'(it_r.score_in) + ply_s;
    sscore = sat16(ss_adj);
    deep = hp.depth >= it_r.depth;
    cut = any_hit && deep &&
          ((hp.flags[0] && pscore <= it_r.alpha) || (hp.flags[1] && pscore >= it_r.beta));
    rscore = it_r.score_in;
    if (any_hit) begin
      if (hp.flags[0]) rscore = (hp.score > it_r.score_in) ? hp.score : it_r.score_in;
      else if (hp.flags[1]) rscore = (hp.score < it_r.score_in) ? hp.score : it_r.score_in;
    end
  end

  logic exec, can_out;
  assign can_out = !ov_r || !out_stall;
  assign exec    = (state_r == ST_EXEC) && can_out;
  assign q_pop   = (state_r == ST_IDLE) && !q_empty;

  out_item_t res;
  always_comb begin
    res = '0;
    we = 1'b0;
    we_way = 4'b0;
    waddr = bkt;
    wkey = it_r.key;
    wpay = hp;
    unique case (it_r.mode)
      MODE_PROBE: begin
        res.hit = any_hit;
        res.move_out = any_hit ? hp.move : 16'd0;
        res.score_out = (any_hit && deep) ? pscore : 16'sd0;
        res.cutoff = cut;
        we = exec && cut;
        we_way[hw] = 1'b1;
        wpay.date = age_r;
      end
      MODE_REFINE: begin
        res.hit = any_hit;
        res.move_out = any_hit ? hp.move : 16'd0;
        res.score_out = rscore;
      end
      MODE_STORE: begin
        res.hit = any_hit;
        we = exec;
        we_way[any_hit ? hw : pick] = 1'b1;
        wpay.date = age_r;
        wpay.move = (any_hit && it_r.move_in == 16'd0) ? hp.move : it_r.move_in;
        wpay.score = sscore;
        wpay.flags = it_r.bound_flags;
        wpay.depth = it_r.depth;
      end
      MODE_AGE: ;
      default: ;
    endcase
    if (state_r == ST_CLEAR) begin
      we = 1'b1;
      we_way = 4'b1111;
      waddr = clr_r[BktW-1:0];
      wkey = '0;
      wpay = '0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_r == (BktW+1)'(Entries/4 - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (!q_empty) state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_EXEC;
      ST_EXEC:  if (can_out) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      age_r   <= 8'd0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + 1'b1;
      if (exec && it_r.mode == MODE_AGE) age_r <= age_r + 8'd1;
      if (exec) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) it_r <= q_data;
    if (exec) od_r <= res;
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;
endmodule

>>> hdl/four_way_transposition_table_unit.sv
// top level of the four-way transposition table
// depends on fwtt_pkg, fwtt_queue, fwtt_back
//
//   port group | dir | handshake
//   in_        | in  | in_valid / in_stall, in_item
//   out_       | out | out_valid / out_stall, out_item
//   cfg_       | in  | cfg_we, cfg_wdata (mate threshold)
//
// each item passes through the back part in order: pop from the queue, bucket read
// (sync read of the four banks), then way compare and write back
// after reset a clearing pass over the Entries/4 buckets zeroes the table; items
// queue (two deep) meanwhile and are then held by in_stall
// out_stall holds the result register; the back part waits on it
module four_way_transposition_table_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fwtt_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output fwtt_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [14:0]         cfg_wdata
);
  import fwtt_pkg::*;

  logic [14:0] thr_r;
  logic        q_full, q_empty, q_pop;
  in_item_t    q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) thr_r <= MateThrRst;
    else if (cfg_we) thr_r <= cfg_wdata;
  end

  assign in_stall = q_full;

  fwtt_queue u_queue (
    .clk, .rst_n,
    .push(in_valid && !q_full), .push_data(in_item), .full(q_full),
    .pop(q_pop), .empty(q_empty), .pop_data(q_data)
  );

  fwtt_back u_back (
    .clk, .rst_n, .mate_thr(thr_r),
    .q_empty, .q_data, .q_pop,
    .out_valid, .out_stall, .out_data(out_item)
  );
endmodule

>>> hdl/fwtt_checker.sv
// port-level checks for the transposition table top level
// depends on fwtt_pkg and four_way_transposition_table_unit
module fwtt_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input fwtt_pkg::out_item_t out_item
);
  import fwtt_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  a_cut_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.cutoff |-> out_item.hit)
    else $error("cutoff without hit");

  a_miss_move: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.hit |-> out_item.move_out == 16'd0 && !out_item.cutoff)
    else $error("move on a miss");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind four_way_transposition_table_unit fwtt_checker u_chk (
  .clk, .rst_n, .out_valid, .out_stall, .out_item
);
